/* hw/rtl/matrix_multiply_4x4_assert.svh */
// assertion macros for the matrix multiply block checks
`ifndef MATRIX_MULTIPLY_4X4_ASSERT_SVH
`define MATRIX_MULTIPLY_4X4_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define MM4_HOLDS(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mm4 check failed");

// next-cycle implication, sampled on clk, off during reset
`define MM4_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mm4 check failed");

`endif

/* hw/rtl/mm4_pkg.sv */
// shared types and constants for the 4x4 fixed-point matrix multiply
`timescale 1ns / 1ps

package mm4_pkg;

	localparam int DATA_W     = 32;
	localparam int ROW_W      = 2;
	localparam int IO_COLS    = 4;
	localparam int KMAX_W     = 3;
	localparam int DIM_DEF    = 4;
	localparam int FRAC_DEF   = 16;
	localparam int S_TDATA_W  = 264;
	localparam int M_TDATA_W  = 136;

	typedef logic [DATA_W-1:0] word_t;
	typedef word_t [IO_COLS-1:0] row_t;

	localparam word_t SAT_MAX = 32'h7fff_ffff;
	localparam word_t SAT_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_LATCH,
		ST_OUT
	} mm4_state_t;

	typedef struct packed {
		logic              load;
		logic              step;
		logic              first;
		logic              last;
		logic              latch;
		logic [ROW_W-1:0]  row;
		logic [KMAX_W-1:0] k;
	} mm4_cmd_t;

	typedef struct packed {
		logic acc_done;
	} mm4_status_t;

endpackage

/* hw/rtl/mm4_ctrl.sv */
// sequencer for loads, dot-product steps and result beats
`timescale 1ns / 1ps

module mm4_ctrl #(
	parameter int DIM = mm4_pkg::DIM_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_final,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output mm4_pkg::mm4_cmd_t   cmd,
	input  mm4_pkg::mm4_status_t status
);
	import mm4_pkg::*;

	localparam int ROWS_OUT = (DIM < IO_COLS) ? DIM : IO_COLS;

	mm4_state_t        state_q, state_n;
	logic [ROW_W-1:0]  row_q, row_n;
	logic [KMAX_W-1:0] k_q, k_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_n;
			row_q   <= row_n;
			k_q     <= k_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		row_n     = row_q;
		k_n       = k_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		cmd.row   = row_q;
		cmd.k     = k_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && in_final) begin
					state_n = ST_RUN;
					row_n   = '0;
					k_n     = '0;
				end
			end
			ST_RUN: begin
				cmd.step  = 1'b1;
				cmd.first = (k_q == '0);
				cmd.last  = (k_q == KMAX_W'(DIM - 1));
				if (k_q == KMAX_W'(DIM - 1)) begin
					state_n = ST_DRAIN;
				end else begin
					k_n = k_q + KMAX_W'(1);
				end
			end
			ST_DRAIN: begin
				if (status.acc_done) begin
					state_n = ST_LATCH;
				end
			end
			ST_LATCH: begin
				cmd.latch = 1'b1;
				state_n   = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (row_q == ROW_W'(ROWS_OUT - 1)) begin
						state_n = ST_IDLE;
					end else begin
						state_n = ST_RUN;
						row_n   = row_q + ROW_W'(1);
						k_n     = '0;
					end
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/mm4_datapath.sv */
// matrix stores, multiplier lanes, accumulators and saturating result register
`timescale 1ns / 1ps

module mm4_datapath #(
	parameter int DIM       = mm4_pkg::DIM_DEF,
	parameter int FRAC_BITS = mm4_pkg::FRAC_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mm4_pkg::mm4_cmd_t          cmd,
	output mm4_pkg::mm4_status_t       status,
	input  logic [mm4_pkg::ROW_W-1:0]  row_index,
	input  mm4_pkg::row_t              a_row,
	input  mm4_pkg::row_t              b_row,
	output logic [mm4_pkg::ROW_W-1:0]  out_row,
	output mm4_pkg::row_t              c_row,
	output logic                       last_row
);
	import mm4_pkg::*;

	localparam int    SR       = (DIM < IO_COLS) ? DIM : IO_COLS;
	localparam int    ROWS_OUT = SR;
	localparam int    ACC_W    = 2 * DATA_W + $clog2(DIM);
	localparam word_t ONE      = word_t'(1) << FRAC_BITS;

	row_t a_q [IO_COLS];
	row_t b_q [IO_COLS];

	word_t a_sel;
	row_t  b_sel;

	word_t a_s1;
	row_t  b_s1;
	logic  v_s1, first_s1, last_s1;

	logic signed [2*DATA_W-1:0] p_s2 [IO_COLS];
	logic                       v_s2, first_s2, last_s2;

	logic signed [ACC_W-1:0] acc_q [IO_COLS];
	logic                    done_q;

	logic signed [ACC_W-1:0] sh [IO_COLS];
	row_t                    sat_row;

	row_t             c_q;
	logic [ROW_W-1:0] out_row_q;
	logic             last_q;

	// matrix stores, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < IO_COLS; r++) begin
				for (int c = 0; c < IO_COLS; c++) begin
					a_q[r][c] <= (r == c) ? ONE : '0;
					b_q[r][c] <= (r == c) ? ONE : '0;
				end
			end
		end else if (cmd.load) begin
			for (int r = 0; r < IO_COLS; r++) begin
				for (int c = 0; c < IO_COLS; c++) begin
					if (r < SR && c < SR && row_index == ROW_W'(r)) begin
						a_q[r][c] <= a_row[c];
						b_q[r][c] <= b_row[c];
					end
				end
			end
		end
	end

	// operand select, entries outside the stored block are identity
	always_comb begin
		a_sel = (KMAX_W'(cmd.row) == cmd.k) ? ONE : '0;
		if (KMAX_W'(cmd.row) < KMAX_W'(SR) && cmd.k < KMAX_W'(SR)) begin
			a_sel = a_q[cmd.row][cmd.k[1:0]];
		end
		for (int c = 0; c < IO_COLS; c++) begin
			b_sel[c] = (cmd.k == KMAX_W'(c)) ? ONE : '0;
			if (cmd.k < KMAX_W'(SR) && c < SR) begin
				b_sel[c] = b_q[cmd.k[1:0]][c];
			end
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= a_sel;
		b_s1 <= b_sel;
		for (int c = 0; c < IO_COLS; c++) begin
			p_s2[c] <= $signed(a_s1) * $signed(b_s1[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			v_s1     <= cmd.step;
			first_s1 <= cmd.first;
			last_s1  <= cmd.last;
			v_s2     <= v_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			done_q   <= v_s2 && last_s2;
		end
	end

	// full-width accumulation per output column
	always_ff @(posedge clk) begin
		if (v_s2) begin
			for (int c = 0; c < IO_COLS; c++) begin
				acc_q[c] <= (first_s2 ? '0 : acc_q[c]) + ACC_W'(p_s2[c]);
			end
		end
	end

	// arithmetic shift and saturation to 32 bits; columns at or beyond DIM are zero
	always_comb begin
		for (int c = 0; c < IO_COLS; c++) begin
			sh[c] = acc_q[c] >>> FRAC_BITS;
			if (c >= DIM) begin
				sat_row[c] = '0;
			end else if (&sh[c][ACC_W-1:DATA_W-1] || ~|sh[c][ACC_W-1:DATA_W-1]) begin
				sat_row[c] = sh[c][DATA_W-1:0];
			end else begin
				sat_row[c] = sh[c][ACC_W-1] ? SAT_MIN : SAT_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			c_q       <= sat_row;
			out_row_q <= cmd.row;
			last_q    <= (cmd.row == ROW_W'(ROWS_OUT - 1));
		end
	end

	assign status.acc_done = done_q;
	assign out_row         = out_row_q;
	assign c_row           = c_q;
	assign last_row        = last_q;

endmodule

/* hw/rtl/matrix_multiply_4x4.sv */
// top level of the 4x4 fixed-point matrix multiply
//
//  channel  dir  beat contents                               tlast
//  s_axis   in   row_index, a_col0..3, b_col0..3             final_load
//  m_axis   out  out_row, c_col0..3                          last_row
//
// a beat with tlast stores its row, then each product row takes DIM
// multiply steps, a drain through the operand, product, accumulator and
// done registers, a saturating latch and an output beat held until taken
// four 32x32 multiplier lanes, one shared left operand per step
// s_axis_tready is high only while no product is in progress
// stores reset asynchronously to identity
`timescale 1ns / 1ps

module matrix_multiply_4x4 #(
	parameter int DIM       = mm4_pkg::DIM_DEF,
	parameter int FRAC_BITS = mm4_pkg::FRAC_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// row_index, a_col0, a_col1, a_col2, a_col3, b_col0, b_col1, b_col2, b_col3
	input  logic [mm4_pkg::S_TDATA_W-1:0]   s_axis_tdata,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// out_row, c_col0, c_col1, c_col2, c_col3
	output logic [mm4_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	output logic                            m_axis_tlast
);
	import mm4_pkg::*;

	localparam int PAD_W = M_TDATA_W - ROW_W - IO_COLS * DATA_W;

	mm4_cmd_t         cmd;
	mm4_status_t      status;
	logic [ROW_W-1:0] row_index;
	row_t             a_row, b_row, c_row;
	logic [ROW_W-1:0] out_row;

	always_comb begin
		row_index = s_axis_tdata[ROW_W-1:0];
		for (int c = 0; c < IO_COLS; c++) begin
			a_row[c] = s_axis_tdata[ROW_W + c * DATA_W +: DATA_W];
			b_row[c] = s_axis_tdata[ROW_W + (IO_COLS + c) * DATA_W +: DATA_W];
		end
	end

	mm4_ctrl #(
		.DIM(DIM)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_final (s_axis_tlast),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.cmd      (cmd),
		.status   (status)
	);

	mm4_datapath #(
		.DIM      (DIM),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.row_index(row_index),
		.a_row    (a_row),
		.b_row    (b_row),
		.out_row  (out_row),
		.c_row    (c_row),
		.last_row (m_axis_tlast)
	);

	assign m_axis_tdata = {{PAD_W{1'b0}}, c_row, out_row};

endmodule

/* hw/rtl/mm4_checker.sv */
// port-level checks for the matrix multiply, bound to the top level
`timescale 1ns / 1ps

`include "matrix_multiply_4x4_assert.svh"

module mm4_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          s_axis_tlast,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [mm4_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic                          m_axis_tlast
);
	import mm4_pkg::*;

	`MM4_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
	`MM4_HOLDS(a_one_side, s_axis_tready, !m_axis_tvalid)
	`MM4_NEXT(a_final_starts, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready && !m_axis_tvalid)
	`MM4_NEXT(a_more_rows, m_axis_tvalid && m_axis_tready && !m_axis_tlast, !s_axis_tready && !m_axis_tvalid)

endmodule

bind matrix_multiply_4x4 mm4_checker u_mm4_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);
